### hdl/plief_pkg.sv
// Package for the positional list block: operation and status codes,
// the cell command struct and the group priority encoder used by the find scan.
// No dependencies.
package plief_pkg;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int GRP_W    = 8;
    localparam int GRP_IDX_W = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_cmd_t;

    function automatic logic [GRP_IDX_W-1:0] first_set(input logic [GRP_W-1:0] bits);
        logic [GRP_IDX_W-1:0] idx;
        idx = '0;
        for (int k = GRP_W - 1; k >= 0; k--) begin
            if (bits[k]) begin
                idx = GRP_IDX_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

### hdl/plief_cell.sv
// One storage cell of the positional list: holds a word, takes a neighbor's
// word when the row shifts, and compares its word with the search key.
// Depends on plief_pkg.
module plief_cell #(
    parameter int WORD_BITS = 32,
    parameter int CNT_W     = 7,
    parameter int INDEX     = 0
) (
    input  logic                  aclk,
    input  plief_pkg::cell_cmd_t  cmd,
    input  logic [CNT_W-1:0]      pos,
    input  logic [CNT_W-1:0]      count,
    input  logic [WORD_BITS-1:0]  key,
    input  logic [WORD_BITS-1:0]  prev_data,
    input  logic [WORD_BITS-1:0]  next_data,
    output logic [WORD_BITS-1:0]  data,
    output logic                  hit
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (cmd.shift_up) begin
            if (MY_IDX > pos) begin
                data_next = prev_data;
            end else if (MY_IDX == pos) begin
                data_next = key;
            end
        end else if (cmd.shift_down) begin
            if (MY_IDX >= pos) begin
                data_next = next_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = (MY_IDX < count) && (data_reg == key);

endmodule

### hdl/positional_list_insert_erase_find.sv
// Top level of the positional list: the row of cells, the entry count,
// the find scan and the two-entry result buffer. Depends on plief_pkg, plief_cell.
//
// An ordered list of up to DEPTH words kept in a row of cells, one word per cell.
// A valid insert or erase shifts the row from the given position on in the cycle
// the request transfer happens; both produce their result at once. Find compares
// every cell with the key in the transfer cycle, then scans the hit vector eight
// cells per cycle from index 0 and stops early at the first group with a hit. One
// request is in work at a time; a finished result may wait at the output while the
// next request is taken. Unwritten cells are never read, since only cells below the
// count take part in a find.
module positional_list_insert_erase_find #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [plief_pkg::OP_W-1:0]         s_op,
    input  logic [CNT_W-1:0]                   s_pos,
    input  logic signed [plief_pkg::VALUE_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [plief_pkg::STATUS_W-1:0]     m_status,
    output logic                               m_found,
    output logic [IDX_W-1:0]                   m_found_index,
    output logic [CNT_W-1:0]                   m_entry_count
);

    localparam int NGRP   = (DEPTH + plief_pkg::GRP_W - 1) / plief_pkg::GRP_W;
    localparam int GCNT_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int VEC_W  = NGRP * plief_pkg::GRP_W;
    localparam int SUM_W  = GCNT_W + plief_pkg::GRP_IDX_W;
    localparam logic [CNT_W-1:0]  CAP      = CNT_W'(DEPTH);
    localparam logic [GCNT_W-1:0] LAST_GRP = GCNT_W'(NGRP - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    typedef struct packed {
        logic [plief_pkg::STATUS_W-1:0] status;
        logic                           found;
        logic [IDX_W-1:0]               index;
        logic [CNT_W-1:0]               count;
    } result_t;

    logic                 state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [VEC_W-1:0]     vec_reg, vec_next;
    logic [GCNT_W-1:0]    grp_reg, grp_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;
    logic                 skid_valid_reg, skid_valid_next;
    result_t              skid_reg, skid_next;

    logic                 accept;
    logic                 res_valid;
    result_t              res;
    logic [WORD_BITS-1:0] key;
    logic [WORD_BITS-1:0] row_data [DEPTH];
    logic [DEPTH-1:0]     row_hit;
    plief_pkg::cell_cmd_t cmd;
    logic                 do_insert, do_erase;
    logic [plief_pkg::GRP_W-1:0] low_grp;
    logic [SUM_W-1:0]     hit_idx;

    assign s_ready = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign key     = WORD_BITS'($unsigned(s_value));

    assign do_insert = accept && (s_op == plief_pkg::OP_INSERT) && (count_reg < CAP)
                       && (s_pos <= count_reg);
    assign do_erase  = accept && (s_op == plief_pkg::OP_ERASE) && (s_pos < count_reg);
    assign cmd.shift_up   = do_insert;
    assign cmd.shift_down = do_erase;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_BITS-1:0] prev_w, next_w;
        if (i == 0) begin : g_first
            assign prev_w = key;
        end else begin : g_prev
            assign prev_w = row_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign next_w = row_data[i];
        end else begin : g_next
            assign next_w = row_data[i+1];
        end
        plief_cell #(
            .WORD_BITS(WORD_BITS),
            .CNT_W    (CNT_W),
            .INDEX    (i)
        ) u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .pos      (s_pos),
            .count    (count_reg),
            .key      (key),
            .prev_data(prev_w),
            .next_data(next_w),
            .data     (row_data[i]),
            .hit      (row_hit[i])
        );
    end

    assign low_grp = vec_reg[plief_pkg::GRP_W-1:0];
    assign hit_idx = {grp_reg, plief_pkg::first_set(low_grp)};

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        vec_next   = vec_reg;
        grp_next   = grp_reg;
        res_valid  = 1'b0;
        res        = '{status: plief_pkg::ST_DONE, found: 1'b0, index: '0, count: count_reg};
        if (state_reg == ST_IDLE) begin
            if (accept) begin
                case (s_op)
                    plief_pkg::OP_INSERT: begin
                        res_valid = 1'b1;
                        if (count_reg >= CAP) begin
                            res.status = plief_pkg::ST_FULL;
                        end else if (s_pos > count_reg) begin
                            res.status = plief_pkg::ST_RANGE;
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    plief_pkg::OP_ERASE: begin
                        res_valid = 1'b1;
                        if (s_pos >= count_reg) begin
                            res.status = plief_pkg::ST_RANGE;
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    plief_pkg::OP_FIND: begin
                        vec_next   = VEC_W'(row_hit);
                        grp_next   = '0;
                        state_next = ST_SCAN;
                    end
                    default: begin
                        res_valid = 1'b1;
                    end
                endcase
                res.count = count_next;
            end
        end else begin
            if (low_grp != '0) begin
                res_valid  = 1'b1;
                res.found  = 1'b1;
                res.index  = IDX_W'(hit_idx);
                state_next = ST_IDLE;
            end else if (grp_reg == LAST_GRP) begin
                res_valid  = 1'b1;
                state_next = ST_IDLE;
            end else begin
                vec_next = vec_reg >> plief_pkg::GRP_W;
                grp_next = grp_reg + GCNT_W'(1);
            end
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = res_valid;
                skid_next       = res;
            end else begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            grp_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            grp_reg        <= grp_next;
        end
    end

    always_ff @(posedge aclk) begin
        vec_reg  <= vec_next;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_reg.status;
    assign m_found       = out_reg.found;
    assign m_found_index = out_reg.index;
    assign m_entry_count = out_reg.count;

endmodule

### hdl/plief_chk.sv
// Port-level checker for the positional list and its bind to the top level.
// Depends on plief_pkg and positional_list_insert_erase_find.
module plief_chk #(
    parameter int DEPTH = 64,
    parameter int CNT_W = 7,
    parameter int IDX_W = 6
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [plief_pkg::STATUS_W-1:0] m_status,
    input logic                           m_found,
    input logic [IDX_W-1:0]               m_found_index,
    input logic [CNT_W-1:0]               m_entry_count
);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_found_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_status == plief_pkg::ST_DONE)
        else $error("find hit with failing status");

    a_miss_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_found_index == '0)
        else $error("index set without a hit");

    a_found_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> CNT_W'(m_found_index) < m_entry_count)
        else $error("hit index outside the list");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found)
            && $stable(m_found_index) && $stable(m_entry_count))
        else $error("result changed while stalled");

endmodule

bind positional_list_insert_erase_find plief_chk #(
    .DEPTH(DEPTH),
    .CNT_W(CNT_W),
    .IDX_W(IDX_W)
) u_plief_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_found      (m_found),
    .m_found_index(m_found_index),
    .m_entry_count(m_entry_count)
);
